@@ rtl/dcvn_pkg.sv @@
// ----------------------------------------------------------------------------
// dcvn_pkg: shared definitions of the DC blocker and von Neumann extractor
// Widths, window size, reset value of the byte limit and the debias stage
// interface structures.
// ----------------------------------------------------------------------------
package dcvn_pkg;

  // The window depth must be a power of two so that the mean is a shift.
  localparam int WINDOW_DEPTH = 256;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_BITS  = 17;
  localparam int SUM_W        = SAMPLE_BITS + IDX_W;
  localparam int FILT_W       = SAMPLE_BITS + 1;
  localparam int BYTE_W       = 8;
  localparam int BIT_CNT_W    = $clog2(BYTE_W);

  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = BYTE_W'(128);

  // Command codes carried in tuser of the input stream.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [FILT_W-1:0]      filt_t;
  typedef logic [BYTE_W-1:0]             byte_t;

  // One item as seen by the debias and packing stage.
  typedef struct packed {
    logic cmd;
    logic sign_bit;
    logic last;
  } debias_in_t;

  typedef struct packed {
    logic  byte_valid;
    byte_t random_byte;
  } debias_out_t;

endpackage

@@ rtl/dc_block_von_neumann_extractor.sv @@
// ----------------------------------------------------------------------------
// dc_block_von_neumann_extractor: DC blocker feeding a von Neumann extractor
// Removes a 256-sample running mean from difference samples, turns the sign
// of each filtered value into a bit, debiases bit pairs and packs bytes.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on the s_axis stream. tuser selects the command: a
// normal sample, or a clear of the DC blocker (history, sum, write position
// and primed flag). tlast marks the final sample of a batch; after it the
// pairing, the partial byte and the per-batch byte count start over.
// Every input word yields exactly one output word on the m_axis stream with
// the filtered sample, the primed flag and, when one completes, a packed byte.
// The byte limit per batch is written through the cfg channel, which is always
// ready; write it only while no words are in flight.
// An accepted word passes through stage 1, stage 2 and the output register.
// One word is accepted per clock cycle while s_axis_tready is high; the
// history memory is read at acceptance and written as it leaves stage 1.
// Consecutive words touch neighbouring entries, so a read never meets a
// pending write of the same entry. Reset empties the history at once through
// per-entry valid bits, so no clearing pass is needed and the block is ready
// in the first cycle after reset. When the receiver stalls, the pipeline
// holds and s_axis_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module dc_block_von_neumann_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: sample [16:0], zero fill [23:17]. tuser: cmd [0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // Output stream. tdata: filtered [17:0], random_byte [25:18], zero [31:26].
  // tuser: byte_valid [0], primed [1].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  // Byte limit register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  // Configuration.
  dcvn_pkg::byte_t byte_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= dcvn_pkg::BYTE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      byte_limit_q <= cfg_data_i;
    end
  end

  // Pipeline flow control: each stage moves when the one after it is free.
  logic out_vld_q, s1_vld_q, s2_vld_q;
  logic out_free, s2_adv, s2_free, s1_adv, s1_free, accept;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s2_adv        = s2_vld_q && out_free;
  assign s2_free       = !s2_vld_q || out_free;
  assign s1_adv        = s1_vld_q && s2_free;
  assign s1_free       = !s1_vld_q || s2_free;
  assign s_axis_tready = s1_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input fields.
  logic              in_cmd;
  dcvn_pkg::sample_t in_smp;

  assign in_cmd = s_axis_tuser[0];
  assign in_smp = s_axis_tdata[dcvn_pkg::SAMPLE_BITS-1:0];

  // Accept stage: write position and primed flag depend only on the order
  // of words, so they advance at acceptance.
  dcvn_pkg::idx_t wr_idx_q, wr_idx_d;
  logic           primed_q, primed_d;
  logic           is_sample;

  assign is_sample = accept && (in_cmd == dcvn_pkg::CMD_SAMPLE);

  always_comb begin
    wr_idx_d = wr_idx_q;
    primed_d = primed_q;
    if (accept) begin
      if (in_cmd == dcvn_pkg::CMD_CLEAR) begin
        wr_idx_d = '0;
        primed_d = 1'b0;
      end else begin
        wr_idx_d = wr_idx_q + 1'b1;
        if (&wr_idx_q) begin
          primed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      primed_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      primed_q <= primed_d;
    end
  end

  // Stage 1 carries the word while the history memory returns the old entry.
  logic              s1_cmd, s1_last, s1_was_primed, s1_primed;
  dcvn_pkg::idx_t    s1_idx;
  dcvn_pkg::sample_t s1_smp;
  dcvn_pkg::sample_t old_smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd        <= in_cmd;
      s1_last       <= s_axis_tlast;
      s1_smp        <= in_smp;
      s1_idx        <= wr_idx_q;
      s1_was_primed <= primed_q;
      s1_primed     <= primed_d;
    end
  end

  dcvn_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (accept && (in_cmd == dcvn_pkg::CMD_CLEAR)),
    .rd_en_i   (is_sample),
    .rd_addr_i (wr_idx_q),
    .rd_data_o (old_smp),
    .wr_en_i   (s1_adv && (s1_cmd == dcvn_pkg::CMD_SAMPLE)),
    .wr_addr_i (s1_idx),
    .wr_data_i (s1_smp)
  );

  // Running sum: add the new sample and drop the one it replaces.
  dcvn_pkg::sum_t sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (s1_cmd == dcvn_pkg::CMD_CLEAR) begin
      sum_d = '0;
    end else begin
      sum_d = sum_q + dcvn_pkg::SUM_W'(s1_smp) - dcvn_pkg::SUM_W'(old_smp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv) begin
      sum_q <= sum_d;
    end
  end

  // Stage 2 holds the updated sum with the sample.
  logic              s2_cmd, s2_last, s2_was_primed, s2_primed;
  dcvn_pkg::sample_t s2_smp;
  dcvn_pkg::sum_t    s2_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_cmd        <= s1_cmd;
      s2_last       <= s1_last;
      s2_smp        <= s1_smp;
      s2_sum        <= sum_d;
      s2_was_primed <= s1_was_primed;
      s2_primed     <= s1_primed;
    end
  end

  // Mean, truncated toward zero: negative sums are biased up by one less
  // than the window before the arithmetic shift.
  dcvn_pkg::sum_t    sum_biased;
  dcvn_pkg::sum_t    mean_full;
  dcvn_pkg::sample_t mean;
  dcvn_pkg::filt_t   filt;

  always_comb begin
    sum_biased = s2_sum;
    if (s2_sum[dcvn_pkg::SUM_W-1]) begin
      sum_biased = s2_sum + dcvn_pkg::SUM_W'(dcvn_pkg::WINDOW_DEPTH - 1);
    end
    mean_full = sum_biased >>> dcvn_pkg::IDX_W;
    mean      = mean_full[dcvn_pkg::SAMPLE_BITS-1:0];
    filt      = '0;
    if (s2_cmd == dcvn_pkg::CMD_SAMPLE && s2_was_primed) begin
      filt = dcvn_pkg::FILT_W'(s2_smp) - dcvn_pkg::FILT_W'(mean);
    end
  end

  // Sign bit: set only for strictly positive values.
  dcvn_pkg::debias_in_t  db_in;
  dcvn_pkg::debias_out_t db_out;

  assign db_in.cmd      = s2_cmd;
  assign db_in.sign_bit = !filt[dcvn_pkg::FILT_W-1] && (filt != '0);
  assign db_in.last     = s2_last;

  dcvn_debias u_debias (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (s2_adv),
    .in_i         (db_in),
    .byte_limit_i (byte_limit_q),
    .out_o        (db_out)
  );

  // Output register.
  dcvn_pkg::filt_t       out_filt_q;
  dcvn_pkg::debias_out_t out_db_q;
  logic                  out_primed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s2_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_filt_q   <= filt;
      out_db_q     <= db_out;
      out_primed_q <= (s2_cmd == dcvn_pkg::CMD_SAMPLE) && s2_primed;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_db_q.random_byte, out_filt_q};
  assign m_axis_tuser  = {out_primed_q, out_db_q.byte_valid};

endmodule

@@ rtl/dcvn_ring.sv @@
// ----------------------------------------------------------------------------
// dcvn_ring: sample history memory of the running mean
// One synchronous read port with registered data and one write port. A
// valid bit per entry makes entries that were never written since reset or
// since the last clear read as zero.
// ----------------------------------------------------------------------------
module dcvn_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               rd_en_i,
  input  dcvn_pkg::idx_t     rd_addr_i,
  output dcvn_pkg::sample_t  rd_data_o,
  input  logic               wr_en_i,
  input  dcvn_pkg::idx_t     wr_addr_i,
  input  dcvn_pkg::sample_t  wr_data_i
);

  dcvn_pkg::sample_t                  mem [dcvn_pkg::WINDOW_DEPTH];
  logic [dcvn_pkg::WINDOW_DEPTH-1:0]  valid_q;
  dcvn_pkg::sample_t                  rd_data_q;
  logic                               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // The valid bit of an entry is set when its read is issued, since the
  // write of that same entry follows as the word leaves the first stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else if (clr_i) begin
      valid_q  <= '0;
    end else if (rd_en_i) begin
      rd_vld_q           <= valid_q[rd_addr_i];
      valid_q[rd_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/dcvn_debias.sv @@
// ----------------------------------------------------------------------------
// dcvn_debias: von Neumann debiasing and byte packing
// Pairs sign bits, keeps the first bit of each unequal pair, packs kept bits
// MSB first and limits the number of bytes per batch.
// ----------------------------------------------------------------------------
module dcvn_debias (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  dcvn_pkg::debias_in_t  in_i,
  input  dcvn_pkg::byte_t       byte_limit_i,
  output dcvn_pkg::debias_out_t out_o
);

  logic                            pair_pending_q, pair_pending_d;
  logic                            first_bit_q, first_bit_d;
  logic [dcvn_pkg::BIT_CNT_W-1:0]  bit_count_q, bit_count_d;
  dcvn_pkg::byte_t                 shift_byte_q, shift_byte_d;
  dcvn_pkg::byte_t                 bytes_emitted_q, bytes_emitted_d;
  dcvn_pkg::byte_t                 shifted;

  assign shifted = {shift_byte_q[dcvn_pkg::BYTE_W-2:0], first_bit_q};

  always_comb begin
    pair_pending_d  = pair_pending_q;
    first_bit_d     = first_bit_q;
    bit_count_d     = bit_count_q;
    shift_byte_d    = shift_byte_q;
    bytes_emitted_d = bytes_emitted_q;
    out_o           = '0;
    if (in_i.cmd == dcvn_pkg::CMD_SAMPLE) begin
      if (!pair_pending_q) begin
        first_bit_d    = in_i.sign_bit;
        pair_pending_d = 1'b1;
      end else begin
        pair_pending_d = 1'b0;
        if (first_bit_q != in_i.sign_bit) begin
          shift_byte_d = shifted;
          bit_count_d  = bit_count_q + 1'b1;
          if (&bit_count_q) begin
            // Byte complete: send it while the batch allowance lasts.
            if (bytes_emitted_q < byte_limit_i) begin
              out_o.byte_valid  = 1'b1;
              out_o.random_byte = shifted;
              bytes_emitted_d   = bytes_emitted_q + 1'b1;
            end
            shift_byte_d = '0;
          end
        end
      end
      if (in_i.last) begin
        pair_pending_d  = 1'b0;
        first_bit_d     = 1'b0;
        bit_count_d     = '0;
        shift_byte_d    = '0;
        bytes_emitted_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_pending_q  <= 1'b0;
      first_bit_q     <= 1'b0;
      bit_count_q     <= '0;
      shift_byte_q    <= '0;
      bytes_emitted_q <= '0;
    end else if (adv_i) begin
      pair_pending_q  <= pair_pending_d;
      first_bit_q     <= first_bit_d;
      bit_count_q     <= bit_count_d;
      shift_byte_q    <= shift_byte_d;
      bytes_emitted_q <= bytes_emitted_d;
    end
  end

endmodule
